>>> rtl/staged_vent_temperature_ladder_unit_defines.svh
// assertion macros shared by the vent ladder checker
`ifndef STAGED_VENT_TEMPERATURE_LADDER_UNIT_DEFINES_SVH
`define STAGED_VENT_TEMPERATURE_LADDER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SVTL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SVTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/svtl_pkg.sv
// shared types, constants and helpers of the vent temperature ladder
package svtl_pkg;

  localparam int HISTORY_DEPTH_DEF = 12;
  localparam int TICK_SECONDS      = 5;
  localparam int WINDOW_STAGES     = 3;
  localparam int FAN_STAGES        = 2;
  localparam int TOP_STAGE_FAN     = WINDOW_STAGES + FAN_STAGES;

  localparam int SLOPE_SPAN      = 10;
  localparam int SLOPE_MIN_COUNT = 11;

  localparam int OPEN_SUS_S  = 180;
  localparam int LONG_SUS_S  = 600;
  localparam int CLOSE_SUS_S = 120;
  localparam int MINUTE_S    = 60;

  localparam int OPEN_RAW   = (OPEN_SUS_S + TICK_SECONDS - 1) / TICK_SECONDS;
  localparam int LONG_RAW   = (LONG_SUS_S + TICK_SECONDS - 1) / TICK_SECONDS;
  localparam int CLOSE_RAW  = (CLOSE_SUS_S + TICK_SECONDS - 1) / TICK_SECONDS;
  localparam int MINUTE_RAW = (MINUTE_S + TICK_SECONDS - 1) / TICK_SECONDS;

  typedef logic [2:0]         stage_t;
  typedef logic [7:0]         tick_cnt_t;
  typedef logic [3:0]         minute_cnt_t;
  typedef logic signed [15:0] temp_t;
  typedef logic signed [16:0] slope_t;

  localparam tick_cnt_t   OPEN_TICKS   = tick_cnt_t'((OPEN_RAW > 255) ? 255 : OPEN_RAW);
  localparam tick_cnt_t   LONG_TICKS   = tick_cnt_t'((LONG_RAW > 255) ? 255 : LONG_RAW);
  localparam tick_cnt_t   CLOSE_TICKS  = tick_cnt_t'((CLOSE_RAW > 255) ? 255 : CLOSE_RAW);
  localparam minute_cnt_t MINUTE_TICKS = minute_cnt_t'((MINUTE_RAW > 15) ? 15 : MINUTE_RAW);
  localparam tick_cnt_t   CNT_MAX      = 8'hFF;

  localparam temp_t  T_OPEN       = 16'sd250;
  localparam temp_t  T_JUMP       = 16'sd280;
  localparam temp_t  T_ESC        = 16'sd255;
  localparam temp_t  T_STEPDN     = 16'sd220;
  localparam temp_t  T_CLOSE      = 16'sd200;
  localparam temp_t  SENS_INVALID = 16'sh7FFF;
  localparam slope_t ESC_SLOPE    = -17'sd5;

  localparam stage_t STAGE_WIN_TOP = stage_t'(WINDOW_STAGES);
  localparam stage_t STAGE_FAN_TOP = stage_t'(TOP_STAGE_FAN);

  localparam logic [1:0] MODE_AUTO     = 2'd0;
  localparam logic [1:0] MODE_MANUAL   = 2'd1;
  localparam logic [1:0] MODE_RELEASED = 2'd2;

  localparam logic [1:0] REG_MODE         = 2'd0;
  localparam logic [1:0] REG_MANUAL_STAGE = 2'd1;
  localparam logic [1:0] REG_FAN_ENABLE   = 2'd2;

  typedef enum logic [3:0] {
    RSN_NONE,
    RSN_SENSOR_LOST,
    RSN_BOOT_WARM,
    RSN_JUMP,
    RSN_OPEN,
    RSN_CLOSE,
    RSN_STEP_DOWN,
    RSN_SLOW_COOL,
    RSN_FAN_OFF
  } reason_t;

  typedef struct packed {
    logic [1:0] mode;
    stage_t     manual_stage;
    logic       fan_enable;
  } cfg_t;

  typedef struct packed {
    temp_t newest;
    temp_t tenth;
    logic  enough;
  } hist_view_t;

  typedef struct packed {
    stage_t     stage;
    logic [1:0] window_level;
    logic [1:0] fan_speed;
    logic       window_drive;
    logic       fan_drive;
    reason_t    change_reason;
    logic       fault_event;
    logic       recovered_event;
    logic       air_valid;
  } result_t;

  function automatic tick_cnt_t sat_inc(input tick_cnt_t v);
    return (v == CNT_MAX) ? v : v + 8'd1;
  endfunction

endpackage

>>> rtl/svtl_in_if.sv
// input channel: one sensor tick per word
interface svtl_in_if;
  logic                 valid;
  logic                 ready;
  logic                 sensor_ok;
  logic signed [15:0]   air_temp;

  modport source (output valid, sensor_ok, air_temp, input ready);
  modport sink (input valid, sensor_ok, air_temp, output ready);
endinterface

// result channel: one drive word per tick
interface svtl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] stage;
  logic [1:0] window_level;
  logic [1:0] fan_speed;
  logic       window_drive;
  logic       fan_drive;
  logic [3:0] change_reason;
  logic       fault_event;
  logic       recovered_event;
  logic       air_valid;

  modport source (output valid, stage, window_level, fan_speed, window_drive, fan_drive,
                  change_reason, fault_event, recovered_event, air_valid, input ready);
  modport sink (input valid, stage, window_level, fan_speed, window_drive, fan_drive,
                change_reason, fault_event, recovered_event, air_valid, output ready);
endinterface

// configuration write channel
interface svtl_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [2:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/svtl_history.sv
// minute temperature history: shift line, fill count and slope taps
module svtl_history #(
  parameter int HISTORY_DEPTH = svtl_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift_en,
  input  svtl_pkg::temp_t        temp,
  output svtl_pkg::hist_view_t   view
);
  import svtl_pkg::*;

  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  temp_t          hist_r [HISTORY_DEPTH];
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (shift_en && (count_r < CW'(HISTORY_DEPTH))) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      hist_r[0] <= temp;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // view as it stands after this tick's shift
  always_comb begin
    view.newest = shift_en ? temp : hist_r[0];
    view.tenth  = shift_en ? hist_r[SLOPE_SPAN-1] : hist_r[SLOPE_SPAN];
    view.enough = (count_nxt >= CW'(SLOPE_MIN_COUNT));
  end

endmodule

>>> rtl/svtl_ladder.sv
// ladder state and single-pass next-state and result logic for one tick
module svtl_ladder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 sensor_ok,
  input  svtl_pkg::temp_t      air_temp,
  input  svtl_pkg::cfg_t       cfg,
  input  svtl_pkg::hist_view_t hist,
  output logic                 hist_shift,
  output svtl_pkg::result_t    res
);
  import svtl_pkg::*;

  stage_t      stage_r, stage_nxt;
  tick_cnt_t   hot_r, hot_nxt;
  tick_cnt_t   warm_r, warm_nxt;
  tick_cnt_t   cold_r, cold_nxt;
  tick_cnt_t   bad_r, bad_nxt;
  tick_cnt_t   dwell_r, dwell_nxt;
  logic        fault_r, fault_nxt;
  logic        boot_r, boot_nxt;
  minute_cnt_t minute_r, minute_nxt;

  reason_t     reason;
  logic        valid;
  logic        auto_mode;
  logic        fault_ev;
  logic        rec_ev;
  logic        shift;
  stage_t      top_stage;
  stage_t      shown;
  slope_t      slope;
  minute_cnt_t minute_inc;

  assign valid      = sensor_ok && (air_temp != SENS_INVALID);
  assign auto_mode  = (cfg.mode == MODE_AUTO);
  assign top_stage  = cfg.fan_enable ? STAGE_FAN_TOP : STAGE_WIN_TOP;
  assign slope      = {hist.newest[15], hist.newest} - {hist.tenth[15], hist.tenth};
  assign minute_inc = minute_r + 4'd1;
  assign shift      = valid && (minute_inc >= MINUTE_TICKS);
  assign hist_shift = step && shift;

  always_comb begin
    stage_nxt  = stage_r;
    hot_nxt    = hot_r;
    warm_nxt   = warm_r;
    cold_nxt   = cold_r;
    bad_nxt    = bad_r;
    dwell_nxt  = dwell_r;
    fault_nxt  = fault_r;
    boot_nxt   = boot_r;
    minute_nxt = minute_r;
    reason     = RSN_NONE;
    fault_ev   = 1'b0;
    rec_ev     = 1'b0;

    if (!cfg.fan_enable && (stage_nxt > STAGE_WIN_TOP)) begin
      stage_nxt = STAGE_WIN_TOP;
      dwell_nxt = '0;
      reason    = RSN_FAN_OFF;
    end

    if (!valid) begin
      bad_nxt = sat_inc(bad_r);
      if ((bad_nxt >= LONG_TICKS) && !fault_r) begin
        fault_nxt = 1'b1;
        fault_ev  = 1'b1;
        if (auto_mode && (stage_nxt != '0)) begin
          stage_nxt = '0;
          dwell_nxt = '0;
          reason    = RSN_SENSOR_LOST;
        end
      end
    end else begin
      if (fault_r) begin
        fault_nxt = 1'b0;
        rec_ev    = 1'b1;
      end
      bad_nxt = '0;

      if (minute_inc >= MINUTE_TICKS) begin
        minute_nxt = '0;
      end else begin
        minute_nxt = minute_inc;
      end

      if (auto_mode) begin
        dwell_nxt = sat_inc(dwell_nxt);
        hot_nxt   = (air_temp >= T_OPEN)   ? sat_inc(hot_r)  : '0;
        warm_nxt  = (air_temp <= T_STEPDN) ? sat_inc(warm_r) : '0;
        cold_nxt  = (air_temp <= T_CLOSE)  ? sat_inc(cold_r) : '0;

        // one-shot warm start on the first usable automatic tick
        if (!boot_r) begin
          boot_nxt = 1'b1;
          if ((air_temp >= T_OPEN) && (stage_nxt == '0)) begin
            stage_nxt = 3'd1;
            dwell_nxt = '0;
            reason    = RSN_BOOT_WARM;
          end
        end

        // every rule below moves the stage, so each one clears dwell
        if ((air_temp >= T_JUMP) && (stage_nxt < STAGE_WIN_TOP)) begin
          stage_nxt = STAGE_WIN_TOP;
          dwell_nxt = '0;
          reason    = RSN_JUMP;
        end else if ((stage_nxt == '0) && (hot_nxt >= OPEN_TICKS)) begin
          stage_nxt = 3'd1;
          dwell_nxt = '0;
          reason    = RSN_OPEN;
        end else if ((stage_nxt != '0) && (cold_nxt >= CLOSE_TICKS)) begin
          stage_nxt = '0;
          dwell_nxt = '0;
          reason    = RSN_CLOSE;
        end else if ((stage_nxt != '0) && (warm_nxt >= LONG_TICKS)) begin
          stage_nxt = stage_nxt - 3'd1;
          dwell_nxt = '0;
          warm_nxt  = '0;
          reason    = RSN_STEP_DOWN;
        end else if ((stage_nxt != '0) && (stage_nxt < top_stage) &&
                     (dwell_nxt >= LONG_TICKS) && (air_temp >= T_ESC) &&
                     hist.enough && (slope > ESC_SLOPE)) begin
          stage_nxt = stage_nxt + 3'd1;
          dwell_nxt = '0;
          reason    = RSN_SLOW_COOL;
        end
      end
    end
  end

  always_comb begin
    if (cfg.mode == MODE_MANUAL) begin
      shown = (cfg.manual_stage > top_stage) ? top_stage : cfg.manual_stage;
    end else begin
      shown = stage_nxt;
    end
  end

  always_comb begin
    res.stage           = shown;
    res.window_level    = (shown > STAGE_WIN_TOP) ? STAGE_WIN_TOP[1:0] : shown[1:0];
    res.fan_speed       = (shown > STAGE_WIN_TOP) ? 2'(shown - STAGE_WIN_TOP) : 2'd0;
    res.window_drive    = (cfg.mode == MODE_AUTO) || (cfg.mode == MODE_MANUAL);
    res.fan_drive       = res.window_drive && cfg.fan_enable;
    res.change_reason   = reason;
    res.fault_event     = fault_ev;
    res.recovered_event = rec_ev;
    res.air_valid       = valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= '0;
      hot_r    <= '0;
      warm_r   <= '0;
      cold_r   <= '0;
      bad_r    <= '0;
      dwell_r  <= '0;
      fault_r  <= 1'b0;
      boot_r   <= 1'b0;
      minute_r <= '0;
    end else if (step) begin
      stage_r  <= stage_nxt;
      hot_r    <= hot_nxt;
      warm_r   <= warm_nxt;
      cold_r   <= cold_nxt;
      bad_r    <= bad_nxt;
      dwell_r  <= dwell_nxt;
      fault_r  <= fault_nxt;
      boot_r   <= boot_nxt;
      minute_r <= minute_nxt;
    end
  end

endmodule

>>> rtl/staged_vent_temperature_ladder_unit.sv
// an accepted input word is held in the input register, then its result word is held in the result register
// throughput: 1 word per cycle while out_ch.ready lets the result register advance; the tick state is
//   updated in one pass between the input register and the result register
// the input register refills while a finished result still waits for out_ch.ready
// reset (rst_n low, synchronous) clears the ladder state, fill count and configuration;
//   the minute history contents are not cleared
module staged_vent_temperature_ladder_unit #(
  parameter int HISTORY_DEPTH = svtl_pkg::HISTORY_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  svtl_in_if.sink       in_ch,
  svtl_out_if.source    out_ch,
  svtl_cfg_if.sink      cfg_ch
);
  import svtl_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_ok_r;
  temp_t       s1_temp_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;
  cfg_t        cfg_r, cfg_nxt;
  logic        advance;
  logic        step;
  logic        in_fire;
  logic        hist_shift;
  hist_view_t  hist_view;
  result_t     res;

  assign advance = !out_valid_r || out_ch.ready;
  assign step    = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MODE:         cfg_nxt.mode         = cfg_ch.data[1:0];
        REG_MANUAL_STAGE: cfg_nxt.manual_stage = cfg_ch.data;
        REG_FAN_ENABLE:   cfg_nxt.fan_enable   = cfg_ch.data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ok_r   <= in_ch.sensor_ok;
      s1_temp_r <= in_ch.air_temp;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  svtl_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (hist_shift),
    .temp     (s1_temp_r),
    .view     (hist_view)
  );

  svtl_ladder u_ladder (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .sensor_ok  (s1_ok_r),
    .air_temp   (s1_temp_r),
    .cfg        (cfg_r),
    .hist       (hist_view),
    .hist_shift (hist_shift),
    .res        (res)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.stage           = out_res_r.stage;
  assign out_ch.window_level    = out_res_r.window_level;
  assign out_ch.fan_speed       = out_res_r.fan_speed;
  assign out_ch.window_drive    = out_res_r.window_drive;
  assign out_ch.fan_drive       = out_res_r.fan_drive;
  assign out_ch.change_reason   = out_res_r.change_reason;
  assign out_ch.fault_event     = out_res_r.fault_event;
  assign out_ch.recovered_event = out_res_r.recovered_event;
  assign out_ch.air_valid       = out_res_r.air_valid;

endmodule

>>> rtl/svtl_checker.sv
// port-level checks on the vent ladder result channel, bound to the top level
`include "staged_vent_temperature_ladder_unit_defines.svh"

module svtl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_stage,
  input logic [1:0] out_window_level,
  input logic [1:0] out_fan_speed,
  input logic       out_window_drive,
  input logic       out_fan_drive,
  input logic [3:0] out_change_reason,
  input logic       out_fault_event,
  input logic       out_recovered_event,
  input logic       out_air_valid
);

  // a stalled word holds
  `SVTL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_stage) && $stable(out_change_reason) && $stable(out_fault_event) && $stable(out_recovered_event), "result word changed while stalled")

  `SVTL_ASSERT_SAME(a_fan_needs_window, out_valid && out_fan_drive, out_window_drive, "fan drive without window drive")

  // window plus fan always adds back up to the stage
  `SVTL_ASSERT_SAME(a_stage_split, out_valid, out_stage == (3'(out_window_level) + 3'(out_fan_speed)), "stage does not split into window and fan")

  `SVTL_ASSERT_SAME(a_recover_valid, out_valid && out_recovered_event, out_air_valid && !out_fault_event, "recovery on a tick without usable air")

endmodule

bind staged_vent_temperature_ladder_unit svtl_checker u_svtl_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_stage           (out_ch.stage),
  .out_window_level    (out_ch.window_level),
  .out_fan_speed       (out_ch.fan_speed),
  .out_window_drive    (out_ch.window_drive),
  .out_fan_drive       (out_ch.fan_drive),
  .out_change_reason   (out_ch.change_reason),
  .out_fault_event     (out_ch.fault_event),
  .out_recovered_event (out_ch.recovered_event),
  .out_air_valid       (out_ch.air_valid)
);

>>> tb/sv/tb_staged_vent_temperature_ladder_unit.sv
// self-checking bench for the staged vent ladder: directed table, then weather-like episodes
module tb_staged_vent_temperature_ladder_unit;
  import svtl_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int          TICK_S     = 5;
  localparam tick_cnt_t   OPEN_HOLD  = tick_cnt_t'((180 + TICK_S - 1) / TICK_S);
  localparam tick_cnt_t   LONG_HOLD  = tick_cnt_t'((600 + TICK_S - 1) / TICK_S);
  localparam tick_cnt_t   CLOSE_HOLD = tick_cnt_t'((120 + TICK_S - 1) / TICK_S);
  localparam minute_cnt_t MINUTE_LEN = minute_cnt_t'((60 + TICK_S - 1) / TICK_S);
  localparam int          HIST_LEN   = 12;

  localparam temp_t HOT_OPEN    = 16'sd250;
  localparam temp_t HOT_JUMP    = 16'sd280;
  localparam temp_t ESC_MIN     = 16'sd255;
  localparam temp_t MILD_MAX    = 16'sd220;
  localparam temp_t COLD_MAX    = 16'sd200;
  localparam temp_t AIR_INVALID = 16'sd32767;
  localparam int    COOL_SLOPE_MIN = -5;

  localparam stage_t WIN_TOP = 3'd3;
  localparam stage_t FAN_TOP = 3'd5;

  localparam int CYCLE_LIMIT = 250000;
  localparam int DIR_ROWS    = 19;
  localparam int PROFILE_TICKS = 200;

  typedef enum {EP_CLIMB, EP_OPEN, EP_COOL, EP_MILD, EP_OUTAGE, EP_NOISE} episode_t;

  typedef struct packed {
    logic [1:0] mode;
    stage_t     manual;
    logic       fan;
    logic       ok;
    temp_t      temp;
    logic       typed;
    result_t    want;
  } dir_row_t;

  localparam result_t UNTYPED = '0;

  logic clk = 1'b0;
  logic rst_n;

  svtl_in_if  in_ch ();
  svtl_out_if out_ch ();
  svtl_cfg_if cfg_ch ();

  staged_vent_temperature_ladder_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // register shadow and ladder state as the block should hold them
  logic [1:0]  cfg_mode   = MODE_AUTO;
  stage_t      cfg_manual = '0;
  logic        cfg_fan    = 1'b0;
  stage_t      cur_stage  = '0;
  tick_cnt_t   hot_cnt = '0, warm_cnt = '0, cold_cnt = '0, bad_cnt = '0, dwell_cnt = '0;
  logic        fault_on = 1'b0, boot_seen = 1'b0;
  temp_t       minute_hist [HIST_LEN] = '{default: '0};
  logic [3:0]  hist_fill = '0;
  minute_cnt_t minute_cnt = '0;
  reason_t     tick_reason = RSN_NONE;

  result_t drive_words_due [$];

  int in_idle_pct = 24, out_idle_pct = 46;
  int ticks_sent = 0, settings_cnt = 0, fail_cnt = 0, cycle_cnt = 0;
  int reason_hits [16] = '{default: 0};
  int recoveries = 0;

  dir_row_t dir_plan [DIR_ROWS] = '{
    '{MODE_AUTO, 3'd0, 1'b0, 1'b0, 16'sd0, 1'b1,
      '{3'd0, 2'd0, 2'd0, 1'b1, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0}},
    '{MODE_AUTO, 3'd0, 1'b0, 1'b1, 16'sd32767, 1'b1,
      '{3'd0, 2'd0, 2'd0, 1'b1, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0}},
    '{MODE_AUTO, 3'd0, 1'b0, 1'b1, 16'sd250, 1'b1,
      '{3'd1, 2'd1, 2'd0, 1'b1, 1'b0, RSN_BOOT_WARM, 1'b0, 1'b0, 1'b1}},
    '{MODE_AUTO, 3'd0, 1'b0, 1'b1, 16'sh8000, 1'b1,
      '{3'd1, 2'd1, 2'd0, 1'b1, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b1}},
    '{MODE_AUTO, 3'd0, 1'b0, 1'b1, 16'sd32766, 1'b1,
      '{3'd3, 2'd3, 2'd0, 1'b1, 1'b0, RSN_JUMP, 1'b0, 1'b0, 1'b1}},
    '{MODE_AUTO, 3'd0, 1'b0, 1'b1, 16'sd279, 1'b0, UNTYPED},
    '{MODE_AUTO, 3'd0, 1'b1, 1'b1, 16'sd280, 1'b0, UNTYPED},
    '{MODE_AUTO, 3'd0, 1'b1, 1'b0, 16'shFFFF, 1'b0, UNTYPED},
    '{MODE_MANUAL, 3'd7, 1'b1, 1'b1, 16'sd100, 1'b1,
      '{3'd5, 2'd3, 2'd2, 1'b1, 1'b1, RSN_NONE, 1'b0, 1'b0, 1'b1}},
    '{MODE_MANUAL, 3'd7, 1'b0, 1'b1, 16'sd120, 1'b1,
      '{3'd3, 2'd3, 2'd0, 1'b1, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b1}},
    '{MODE_MANUAL, 3'd4, 1'b1, 1'b1, 16'sd230, 1'b1,
      '{3'd4, 2'd3, 2'd1, 1'b1, 1'b1, RSN_NONE, 1'b0, 1'b0, 1'b1}},
    '{MODE_MANUAL, 3'd0, 1'b1, 1'b1, 16'sd230, 1'b1,
      '{3'd0, 2'd0, 2'd0, 1'b1, 1'b1, RSN_NONE, 1'b0, 1'b0, 1'b1}},
    '{MODE_RELEASED, 3'd5, 1'b1, 1'b1, 16'sd260, 1'b1,
      '{3'd3, 2'd3, 2'd0, 1'b0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b1}},
    '{MODE_SPARE, 3'd5, 1'b1, 1'b1, -16'sd300, 1'b1,
      '{3'd3, 2'd3, 2'd0, 1'b0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b1}},
    '{MODE_SPARE, 3'd5, 1'b1, 1'b0, 16'sd32767, 1'b0, UNTYPED},
    '{MODE_AUTO, 3'd6, 1'b1, 1'b1, 16'sd150, 1'b0, UNTYPED},
    '{MODE_AUTO, 3'd6, 1'b1, 1'b1, 16'sh5555, 1'b0, UNTYPED},
    '{MODE_AUTO, 3'd6, 1'b1, 1'b1, 16'shAAAA, 1'b0, UNTYPED},
    '{MODE_AUTO, 3'd6, 1'b0, 1'b1, 16'sd200, 1'b0, UNTYPED}
  };

  function automatic tick_cnt_t bump(input tick_cnt_t v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic void move_stage(input stage_t s, input reason_t why);
    if (s != cur_stage) begin
      cur_stage   = s;
      dwell_cnt   = '0;
      tick_reason = why;
    end
  endfunction

  // one control tick of the ladder; returns the drive word it should produce
  function automatic result_t ladder_tick(input logic ok, input temp_t t);
    result_t r;
    logic    usable;
    logic    drive;
    stage_t  top;
    stage_t  shown;
    int      slope;
    r           = '0;
    usable      = ok && (t != AIR_INVALID);
    top         = cfg_fan ? FAN_TOP : WIN_TOP;
    tick_reason = RSN_NONE;
    if (!cfg_fan && cur_stage > WIN_TOP) move_stage(WIN_TOP, RSN_FAN_OFF);
    if (!usable) begin
      bad_cnt = bump(bad_cnt);
      if (bad_cnt >= LONG_HOLD && !fault_on) begin
        fault_on      = 1'b1;
        r.fault_event = 1'b1;
        if (cfg_mode == MODE_AUTO) move_stage(3'd0, RSN_SENSOR_LOST);
      end
    end else begin
      if (fault_on) begin
        fault_on          = 1'b0;
        r.recovered_event = 1'b1;
      end
      bad_cnt    = '0;
      minute_cnt = minute_cnt + 4'd1;
      if (minute_cnt >= MINUTE_LEN) begin
        minute_cnt = '0;
        for (int i = HIST_LEN - 1; i > 0; i--) minute_hist[i] = minute_hist[i - 1];
        minute_hist[0] = t;
        if (hist_fill < HIST_LEN) hist_fill = hist_fill + 4'd1;
      end
      if (cfg_mode == MODE_AUTO) begin
        dwell_cnt = bump(dwell_cnt);
        hot_cnt   = (t >= HOT_OPEN) ? bump(hot_cnt) : 8'd0;
        warm_cnt  = (t <= MILD_MAX) ? bump(warm_cnt) : 8'd0;
        cold_cnt  = (t <= COLD_MAX) ? bump(cold_cnt) : 8'd0;
        if (!boot_seen) begin
          boot_seen = 1'b1;
          if (t >= HOT_OPEN && cur_stage == 3'd0) move_stage(3'd1, RSN_BOOT_WARM);
        end
        // ten-minute trend, newest minute against the one ten entries back
        slope = int'(minute_hist[0]) - int'(minute_hist[10]);
        if (t >= HOT_JUMP && cur_stage < WIN_TOP) begin
          move_stage(WIN_TOP, RSN_JUMP);
        end else if (cur_stage == 3'd0 && hot_cnt >= OPEN_HOLD) begin
          move_stage(3'd1, RSN_OPEN);
        end else if (cur_stage != 3'd0 && cold_cnt >= CLOSE_HOLD) begin
          move_stage(3'd0, RSN_CLOSE);
        end else if (cur_stage != 3'd0 && warm_cnt >= LONG_HOLD) begin
          move_stage(cur_stage - 3'd1, RSN_STEP_DOWN);
          warm_cnt = '0;
        end else if (cur_stage != 3'd0 && cur_stage < top && dwell_cnt >= LONG_HOLD &&
                     t >= ESC_MIN && hist_fill >= 4'd11 && slope > COOL_SLOPE_MIN) begin
          move_stage(cur_stage + 3'd1, RSN_SLOW_COOL);
        end
      end
    end
    if (cfg_mode == MODE_MANUAL) shown = (cfg_manual > top) ? top : cfg_manual;
    else shown = cur_stage;
    drive             = (cfg_mode == MODE_AUTO || cfg_mode == MODE_MANUAL);
    r.stage           = shown;
    r.window_level    = (shown > WIN_TOP) ? 2'd3 : shown[1:0];
    r.fan_speed       = (shown > WIN_TOP) ? 2'(shown - WIN_TOP) : 2'd0;
    r.window_drive    = drive;
    r.fan_drive       = drive & cfg_fan;
    r.change_reason   = tick_reason;
    r.air_valid       = usable;
    return r;
  endfunction

  function automatic temp_t pick_temp(input int lo, input int hi);
    return temp_t'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic episode_t choose_episode();
    int r;
    r = $urandom_range(99);
    if (r < 25) return EP_CLIMB;
    if (r < 40) return EP_OPEN;
    if (r < 55) return EP_COOL;
    if (r < 70) return EP_MILD;
    if (r < 85) return EP_OUTAGE;
    return EP_NOISE;
  endfunction

  task automatic send_tick(input logic ok, input temp_t t, input logic typed,
                           input result_t want);
    result_t guess;
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sensor_ok <= ok;
    in_ch.air_temp  <= t;
    do @(posedge clk); while (!in_ch.ready);
    guess = ladder_tick(ok, t);
    drive_words_due.push_back(typed ? want : guess);
    ticks_sent++;
  endtask

  // stop sending and let every pending word drain before touching registers
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (drive_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_MODE:         cfg_mode   = data[1:0];
      REG_MANUAL_STAGE: cfg_manual = data;
      REG_FAN_ENABLE:   cfg_fan    = data[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [1:0] mode, input stage_t manual, input logic fan);
    logic [2:0] junk;
    junk = 3'($urandom);
    quiesce();
    // upper data bits are don't-care for the narrow registers
    write_reg(REG_MODE, {junk[2], mode});
    write_reg(REG_MANUAL_STAGE, manual);
    write_reg(REG_FAN_ENABLE, {junk[1:0], fan});
    cfg_ch.valid <= 1'b0;
    settings_cnt++;
  endtask

  task automatic run_episode(input episode_t ep);
    int    n;
    int    k;
    logic  ok;
    temp_t t;
    case (ep)
      EP_CLIMB: begin
        send_tick(1'b1, pick_temp(280, 600), 1'b0, UNTYPED);
        n = 121 + $urandom_range(130);
      end
      EP_OPEN:   n = 37 + $urandom_range(8);
      EP_COOL:   n = 25 + $urandom_range(7);
      EP_MILD:   n = 121 + $urandom_range(7);
      EP_OUTAGE: n = ($urandom_range(9) < 3) ? 5 + $urandom_range(55) : 120 + $urandom_range(10);
      default:   n = 4 + $urandom_range(16);
    endcase
    for (k = 0; k < n; k++) begin
      ok = 1'b1;
      case (ep)
        EP_CLIMB: t = pick_temp(262, 268);
        EP_OPEN:  t = pick_temp(250, 279);
        EP_COOL:  t = pick_temp(-400, 200);
        EP_MILD:  t = pick_temp(201, 220);
        EP_OUTAGE: begin
          ok = 1'($urandom);
          t  = ok ? AIR_INVALID : temp_t'($urandom);
        end
        default: begin
          ok = 1'($urandom);
          t  = ($urandom_range(7) == 0) ? AIR_INVALID : temp_t'($urandom);
        end
      endcase
      // rare sensor dropout inside a steady run
      if (ep < EP_OUTAGE && $urandom_range(49) == 0) ok = 1'b0;
      send_tick(ok, t, 1'b0, UNTYPED);
    end
  endtask

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin : score
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_words_due.size() == 0) begin
        fail_cnt++;
        $display("%0t: drive word with none pending, expected nothing got stage %0d",
                 $time, out_ch.stage);
      end else begin
        want = drive_words_due.pop_front();
        reason_hits[want.change_reason]++;
        if (want.recovered_event) recoveries++;
        check_field("stage", want.stage, out_ch.stage);
        check_field("window_level", want.window_level, out_ch.window_level);
        check_field("fan_speed", want.fan_speed, out_ch.fan_speed);
        check_field("window_drive", want.window_drive, out_ch.window_drive);
        check_field("fan_drive", want.fan_drive, out_ch.fan_drive);
        check_field("change_reason", want.change_reason, out_ch.change_reason);
        check_field("fault_event", want.fault_event, out_ch.fault_event);
        check_field("recovered_event", want.recovered_event, out_ch.recovered_event);
        check_field("air_valid", want.air_valid, out_ch.air_valid);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d words still pending",
               cycle_cnt, drive_words_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int         goal;
    int         r;
    int         directed_cnt;
    logic [1:0] mode;
    logic       fan;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sensor_ok = 1'b0;
    in_ch.air_temp  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_settings(dir_plan[0].mode, dir_plan[0].manual, dir_plan[0].fan);
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_plan[i].mode != cfg_mode || dir_plan[i].manual != cfg_manual ||
          dir_plan[i].fan != cfg_fan)
        load_settings(dir_plan[i].mode, dir_plan[i].manual, dir_plan[i].fan);
      send_tick(dir_plan[i].ok, dir_plan[i].temp, dir_plan[i].typed, dir_plan[i].want);
    end
    directed_cnt = ticks_sent;

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin in_idle_pct = 24; out_idle_pct = 46; end
        1: begin in_idle_pct = 46; out_idle_pct = 24; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      goal = ticks_sent + PROFILE_TICKS;
      while (ticks_sent < goal) begin
        // mostly the automatic ladder with fans, so the upper stages get reached
        r = $urandom_range(99);
        if (r < 55) begin
          mode = MODE_AUTO;
          fan  = 1'b1;
        end else if (r < 75) begin
          mode = MODE_AUTO;
          fan  = 1'b0;
        end else begin
          mode = 2'($urandom);
          fan  = 1'($urandom);
        end
        load_settings(mode, 3'($urandom), fan);
        repeat (2) run_episode(choose_episode());
      end
    end

    in_ch.valid <= 1'b0;
    while (drive_words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d ticks sent (%0d from the directed table) across %0d register settings",
             ticks_sent, directed_cnt, settings_cnt);
    $display("changes: boot %0d jump %0d open %0d close %0d stepdown %0d slowcool %0d %s",
             reason_hits[RSN_BOOT_WARM], reason_hits[RSN_JUMP], reason_hits[RSN_OPEN],
             reason_hits[RSN_CLOSE], reason_hits[RSN_STEP_DOWN], reason_hits[RSN_SLOW_COOL],
             $sformatf("fanoff %0d sensorlost %0d recoveries %0d",
                       reason_hits[RSN_FAN_OFF], reason_hits[RSN_SENSOR_LOST], recoveries));
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
